// File: hdl/la_pkg.sv
// la_pkg: shared widths, register codes, pipeline depths and types for levels_adjust
// no dependencies; used by every module of the block by scoped names

package la_pkg;

  // channel sample width and saturation limits
  localparam int DATA_W      = 16;
  localparam int CHANNEL_MAX = 32768;
  localparam int MAX_8BIT    = 255;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_W  = 16;

  typedef enum logic [CFG_AW-1:0] {
    REG_DEPTH_MODE = 3'd0,
    REG_IN_LOW     = 3'd1,
    REG_IN_MIDDLE  = 3'd2,
    REG_IN_HIGH    = 3'd3,
    REG_OUT_LOW    = 3'd4,
    REG_OUT_HIGH   = 3'd5
  } la_reg_t;

  localparam logic [DATA_W-1:0] RST_IN_LOW    = 16'd0;
  localparam logic [DATA_W-1:0] RST_IN_MIDDLE = 16'd128;
  localparam logic [DATA_W-1:0] RST_IN_HIGH   = 16'd255;
  localparam logic [DATA_W-1:0] RST_OUT_LOW   = 16'd0;
  localparam logic [DATA_W-1:0] RST_OUT_HIGH  = 16'd255;

  // divider: dividend/quotient width, quotient bits per stage
  localparam int QW         = 34;
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = QW / DIV_BPS;
  localparam int DV_W       = DATA_W + 1;   // divisor is twice the segment width
  localparam int REM_W      = DV_W;

  // pipeline depth
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES  = 2;
  localparam int N_STAGES     = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  // values derived from the configuration registers, static while items flow
  typedef struct packed {
    logic [DATA_W-1:0]        chmax;
    logic [DATA_W-1:0]        in_low;
    logic [DATA_W-1:0]        in_mid;
    logic [DATA_W-1:0]        in_high;
    logic signed [DATA_W:0]   fac_lo;   // mid
    logic signed [DATA_W:0]   fac_hi;   // span - mid
    logic                     neg_lo;   // lower segment width negative
    logic                     neg_hi;
    logic [DATA_W-1:0]        dabs_lo;  // magnitude of lower segment width
    logic [DATA_W-1:0]        dabs_hi;
    logic signed [DATA_W+1:0] off_lo;   // out_low
    logic signed [DATA_W+1:0] off_hi;   // out_low + mid
  } la_cfg_t;

  // side bits that travel with a sample through the divider
  typedef struct packed {
    logic upper;  // upper segment
    logic flat;   // zero-width segment
    logic neg;    // rounded numerator negative
  } la_side_t;

endpackage

// File: hdl/la_front.sv
// la_front: clamp, segment select, multiply and numerator forming for one channel
// depends on la_pkg; four register stages advanced by per-stage enables

module la_front (
  input  logic                                clk,
  input  logic [la_pkg::FRONT_STAGES-1:0]     en,
  input  la_pkg::la_cfg_t                     cfg,
  input  logic [la_pkg::DATA_W-1:0]           sample,
  output logic [la_pkg::QW-1:0]               mag,
  output la_pkg::la_side_t                    side
);

  logic [la_pkg::DATA_W-1:0]        s_lim;
  logic [la_pkg::DATA_W-1:0]        n_nxt, n_r;
  logic                             up2_nxt, up2_r, up3_r;
  logic signed [la_pkg::DATA_W+1:0] a_nxt, a_r;
  logic signed [la_pkg::DATA_W:0]   fac;
  logic signed [34:0]               p_nxt, p_r;
  logic                             negd;
  logic [la_pkg::DATA_W-1:0]        dabs;
  logic signed [34:0]               pn;
  logic signed [36:0]               num2;
  logic [la_pkg::QW-1:0]            mag_nxt, mag_r;
  la_pkg::la_side_t                 side_nxt, side_r;

  // stage 1: limit to channel maximum, clamp to input range
  always_comb begin
    s_lim = (sample > cfg.chmax) ? cfg.chmax : sample;
    if (s_lim < cfg.in_low) begin
      n_nxt = cfg.in_low;
    end else if (s_lim > cfg.in_high) begin
      n_nxt = cfg.in_high;
    end else begin
      n_nxt = s_lim;
    end
  end

  // stage 2: pick segment, distance from its start
  always_comb begin
    up2_nxt = !(n_r < cfg.in_mid);
    if (up2_nxt) begin
      a_nxt = 18'(n_r) - 18'(cfg.in_mid);
    end else begin
      a_nxt = 18'(n_r) - 18'(cfg.in_low);
    end
  end

  // stage 3: scale by segment output height
  always_comb begin
    fac   = up2_r ? cfg.fac_hi : cfg.fac_lo;
    p_nxt = a_r * fac;
  end

  // stage 4: normalise sign of the width, form 2*num + den and its magnitude
  always_comb begin
    negd     = up3_r ? cfg.neg_hi : cfg.neg_lo;
    dabs     = up3_r ? cfg.dabs_hi : cfg.dabs_lo;
    pn       = negd ? -p_r : p_r;
    num2     = $signed({pn[34], pn, 1'b0}) + $signed({21'b0, dabs});
    mag_nxt  = num2[36] ? la_pkg::QW'(-num2) : la_pkg::QW'(num2);
    side_nxt.upper = up3_r;
    side_nxt.flat  = (dabs == '0);
    side_nxt.neg   = num2[36];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n_r <= n_nxt;
    end
    if (en[1]) begin
      up2_r <= up2_nxt;
      a_r   <= a_nxt;
    end
    if (en[2]) begin
      up3_r <= up2_r;
      p_r   <= p_nxt;
    end
    if (en[3]) begin
      mag_r  <= mag_nxt;
      side_r <= side_nxt;
    end
  end

  assign mag  = mag_r;
  assign side = side_r;

endmodule

// File: hdl/la_div.sv
// la_div: pipelined restoring divider, a fixed number of quotient bits per stage
// depends on la_pkg; divisor is taken from the static configuration by segment

module la_div (
  input  logic                              clk,
  input  logic [la_pkg::DIV_STAGES-1:0]     en,
  input  la_pkg::la_cfg_t                   cfg,
  input  logic [la_pkg::QW-1:0]             dividend,
  input  la_pkg::la_side_t                  side_in,
  output logic [la_pkg::QW-1:0]             quot,
  output logic                              rem_nz,
  output la_pkg::la_side_t                  side_out
);

  logic [la_pkg::QW-1:0]    x_r    [la_pkg::DIV_STAGES];
  logic [la_pkg::REM_W-1:0] rem_r  [la_pkg::DIV_STAGES];
  la_pkg::la_side_t         side_r [la_pkg::DIV_STAGES];

  for (genvar g = 0; g < la_pkg::DIV_STAGES; g++) begin : g_stage
    logic [la_pkg::QW-1:0]    x_src;
    logic [la_pkg::REM_W-1:0] rem_src;
    la_pkg::la_side_t         side_src;
    logic [la_pkg::DV_W-1:0]  dv;
    logic [la_pkg::QW-1:0]    x_nxt;
    logic [la_pkg::REM_W-1:0] rem_nxt;

    if (g == 0) begin : g_first
      assign x_src    = dividend;
      assign rem_src  = '0;
      assign side_src = side_in;
    end else begin : g_next
      assign x_src    = x_r[g-1];
      assign rem_src  = rem_r[g-1];
      assign side_src = side_r[g-1];
    end

    assign dv = side_src.upper ? {cfg.dabs_hi, 1'b0} : {cfg.dabs_lo, 1'b0};

    always_comb begin
      logic [la_pkg::REM_W:0] trial;
      logic                   qb;
      x_nxt   = x_src;
      rem_nxt = rem_src;
      for (int k = 0; k < la_pkg::DIV_BPS; k++) begin
        trial = {rem_nxt, x_nxt[la_pkg::QW-1]};
        if (trial >= {1'b0, dv}) begin
          rem_nxt = la_pkg::REM_W'(trial - {1'b0, dv});
          qb      = 1'b1;
        end else begin
          rem_nxt = trial[la_pkg::REM_W-1:0];
          qb      = 1'b0;
        end
        x_nxt = {x_nxt[la_pkg::QW-2:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        x_r[g]    <= x_nxt;
        rem_r[g]  <= rem_nxt;
        side_r[g] <= side_src;
      end
    end
  end

  assign quot     = x_r[la_pkg::DIV_STAGES-1];
  assign rem_nz   = |rem_r[la_pkg::DIV_STAGES-1];
  assign side_out = side_r[la_pkg::DIV_STAGES-1];

endmodule

// File: hdl/la_chan.sv
// la_chan: full mapping pipeline of one colour channel
// depends on la_pkg, la_front and la_div; adds floor correction, offset and saturation

module la_chan (
  input  logic                            clk,
  input  logic [la_pkg::N_STAGES-1:0]     en,
  input  la_pkg::la_cfg_t                 cfg,
  input  logic [la_pkg::DATA_W-1:0]       sample,
  output logic [la_pkg::DATA_W-1:0]       result
);

  localparam int B1 = la_pkg::N_STAGES - 2;
  localparam int B2 = la_pkg::N_STAGES - 1;

  logic [la_pkg::QW-1:0]        mag;
  la_pkg::la_side_t             side_f, side_d;
  logic [la_pkg::QW-1:0]        quot;
  logic                         rem_nz;
  logic [la_pkg::QW:0]          qm;
  logic signed [la_pkg::QW:0]   qs_nxt, qs_r;
  logic                         up_r;
  logic signed [la_pkg::DATA_W+1:0] off;
  logic [la_pkg::QW+1:0]        sum;
  logic [la_pkg::DATA_W-1:0]    res_nxt, res_r;

  la_front u_front (
    .clk    (clk),
    .en     (en[la_pkg::FRONT_STAGES-1:0]),
    .cfg    (cfg),
    .sample (sample),
    .mag    (mag),
    .side   (side_f)
  );

  la_div u_div (
    .clk      (clk),
    .en       (en[la_pkg::FRONT_STAGES +: la_pkg::DIV_STAGES]),
    .cfg      (cfg),
    .dividend (mag),
    .side_in  (side_f),
    .quot     (quot),
    .rem_nz   (rem_nz),
    .side_out (side_d)
  );

  // floor of a negative quotient rounds away from zero when inexact
  always_comb begin
    qm = {1'b0, quot} + (la_pkg::QW+1)'(rem_nz);
    if (side_d.flat) begin
      qs_nxt = '0;
    end else if (side_d.neg) begin
      qs_nxt = -$signed(qm);
    end else begin
      qs_nxt = $signed({1'b0, quot});
    end
  end

  // add segment base and saturate to the channel range
  always_comb begin
    off = up_r ? cfg.off_hi : cfg.off_lo;
    sum = {qs_r[la_pkg::QW], qs_r}
        + {{(la_pkg::QW + 2 - (la_pkg::DATA_W + 2)){off[la_pkg::DATA_W+1]}}, off};
    if (sum[la_pkg::QW+1]) begin
      res_nxt = '0;
    end else if (sum > (la_pkg::QW+2)'(cfg.chmax)) begin
      res_nxt = cfg.chmax;
    end else begin
      res_nxt = sum[la_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[B1]) begin
      qs_r <= qs_nxt;
      up_r <= side_d.upper;
    end
    if (en[B2]) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

// File: hdl/levels_adjust.sv
// levels_adjust: top level, configuration registers, pipeline flow control, three channels
// depends on la_pkg and la_chan

// Levels correction of RGB pixels. Each channel is limited to the channel maximum
// (255 in 8-bit mode, 32768 in wide mode), clamped to [in_low, in_high] and mapped
// through two straight segments meeting at in_middle, where the output is out_low
// plus the floor of half the output span; the exact quotient is rounded half up and
// the result saturated to [0, channel maximum]. One pixel is accepted every cycle
// when the output side keeps up; the pipeline has 4 front stages (clamp,
// segment select, multiply, numerator), a 17-stage divider producing two quotient
// bits per stage, and 2 back stages (floor correction, offset and saturation).
// Every stage carries a valid bit and only stalls while it and all stages after it
// are full, so empty slots are squeezed out and an item can be taken while a result
// waits at the output. Registers are written through cfg_we/cfg_addr/cfg_wdata and
// take effect at once; write them only while no item is in flight.

module levels_adjust #(
  parameter int CHANNEL_MAX = la_pkg::CHANNEL_MAX  // wide mode channel maximum
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input pixel items
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [3*la_pkg::DATA_W-1:0]  in_tdata,   // red_in, green_in, blue_in
  // corrected pixel items
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [3*la_pkg::DATA_W-1:0]  out_tdata,  // red_out, green_out, blue_out
  // register writes
  input  logic                         cfg_we,
  input  logic [la_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [la_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int N = la_pkg::N_STAGES;
  localparam int W = la_pkg::DATA_W;

  logic         depth_mode_r;
  logic [W-1:0] in_low_r, in_mid_r, in_high_r, out_low_r, out_high_r;

  logic signed [W:0] span, mid, den_lo, den_hi;
  la_pkg::la_cfg_t   cfg;

  logic [N-1:0] vld_r, vld_nxt, en;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r <= 1'b0;
      in_low_r     <= la_pkg::RST_IN_LOW;
      in_mid_r     <= la_pkg::RST_IN_MIDDLE;
      in_high_r    <= la_pkg::RST_IN_HIGH;
      out_low_r    <= la_pkg::RST_OUT_LOW;
      out_high_r   <= la_pkg::RST_OUT_HIGH;
    end else if (cfg_we) begin
      unique case (la_pkg::la_reg_t'(cfg_addr))
        la_pkg::REG_DEPTH_MODE: depth_mode_r <= cfg_wdata[0];
        la_pkg::REG_IN_LOW:     in_low_r     <= cfg_wdata[W-1:0];
        la_pkg::REG_IN_MIDDLE:  in_mid_r     <= cfg_wdata[W-1:0];
        la_pkg::REG_IN_HIGH:    in_high_r    <= cfg_wdata[W-1:0];
        la_pkg::REG_OUT_LOW:    out_low_r    <= cfg_wdata[W-1:0];
        la_pkg::REG_OUT_HIGH:   out_high_r   <= cfg_wdata[W-1:0];
        default: ;
      endcase
    end
  end

  // per-setting constants shared by all channels and stages
  always_comb begin
    span   = (W+1)'(out_high_r) - (W+1)'(out_low_r);
    mid    = span >>> 1;                       // floor of half the span
    den_lo = (W+1)'(in_mid_r) - (W+1)'(in_low_r);
    den_hi = (W+1)'(in_high_r) - (W+1)'(in_mid_r);

    cfg.chmax   = depth_mode_r ? W'(CHANNEL_MAX) : W'(la_pkg::MAX_8BIT);
    cfg.in_low  = in_low_r;
    cfg.in_mid  = in_mid_r;
    cfg.in_high = in_high_r;
    cfg.fac_lo  = mid;
    cfg.fac_hi  = span - mid;
    cfg.neg_lo  = den_lo[W];
    cfg.neg_hi  = den_hi[W];
    cfg.dabs_lo = den_lo[W] ? W'(-den_lo) : W'(den_lo);
    cfg.dabs_hi = den_hi[W] ? W'(-den_hi) : W'(den_hi);
    cfg.off_lo  = $signed({2'b00, out_low_r});
    cfg.off_hi  = $signed({2'b00, out_low_r}) + $signed({mid[W], mid});
  end

  // a stage may load when it or any stage after it has room
  for (genvar i = 0; i < N; i++) begin : g_en
    assign en[i] = out_tready || !(&vld_r[N-1:i]);
  end

  assign vld_nxt = {vld_r[N-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_nxt[i];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[N-1];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    la_chan u_chan (
      .clk    (clk),
      .en     (en),
      .cfg    (cfg),
      .sample (in_tdata[c*W +: W]),
      .result (out_tdata[c*W +: W])
    );
  end

endmodule

// File: sim/tb.sv
// tb: self-checking bench for levels_adjust, streams rgb pixels through the block
// depends on la_pkg and levels_adjust; expected pixels come from an in-bench level mapper

`timescale 1ns / 1ps

module tb;
  import la_pkg::*;

  // register indexes with no register behind them, writes must be ignored
  localparam logic [CFG_AW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_B = 3'd7;

  localparam longint LIMIT_NS   = 64'd20_000_000;  // 20 ms
  localparam int     N_PHASES   = 10;
  localparam int     PHASE_PIX  = 180;
  localparam int     LONG_HOLD  = 250;

  // red sits in the lowest bits, as on tdata
  typedef struct packed {
    logic [DATA_W-1:0] blue;
    logic [DATA_W-1:0] green;
    logic [DATA_W-1:0] red;
  } pixel_t;

  // local copy of the register file
  typedef struct {
    logic              depth;
    logic [DATA_W-1:0] in_low;
    logic [DATA_W-1:0] in_mid;
    logic [DATA_W-1:0] in_high;
    logic [DATA_W-1:0] out_low;
    logic [DATA_W-1:0] out_high;
  } levels_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CFG_AW-1:0] addr;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] r, g, b;     // pixel sent
    logic [DATA_W-1:0] er, eg, eb;  // typed-in result for known rows
  } stim_row_t;

  // directed table: reset values, both depths, then the corner cases of the mapping
  localparam int N_ROWS = 48;
  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    // reset setting: 8-bit, 0..128..255 onto 0..255
    '{ROW_PIX_KNOWN, REG_DEPTH_MODE, '0, 16'd0,     16'd0,     16'd0,
      16'd0,     16'd0,     16'd0},
    '{ROW_PIX_KNOWN, REG_DEPTH_MODE, '0, 16'd255,   16'd128,   16'd65535,
      16'd255,   16'd127,   16'd255},
    '{ROW_PIX,       REG_DEPTH_MODE, '0, 16'd32768, 16'd1,     16'd254,   '0, '0, '0},
    '{ROW_PIX,       REG_DEPTH_MODE, '0, 16'd127,   16'd129,   16'd200,   '0, '0, '0},
    // wide mode, full range
    '{ROW_CFG, REG_DEPTH_MODE, 16'd1,     '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_MIDDLE,  16'd16384, '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_HIGH,    16'd32768, '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_OUT_HIGH,   16'd32768, '0, '0, '0, '0, '0, '0},
    '{ROW_PIX_KNOWN, REG_DEPTH_MODE, '0, 16'd0,     16'd32768, 16'd65535,
      16'd0,     16'd32768, 16'd32768},
    '{ROW_PIX,       REG_DEPTH_MODE, '0, 16'd16384, 16'd12345, 16'd40000, '0, '0, '0},
    '{ROW_PIX,       REG_DEPTH_MODE, '0, 16'd16383, 16'd1,     16'd32767, '0, '0, '0},
    // black point above white point
    '{ROW_CFG, REG_IN_LOW,     16'd30000, '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_MIDDLE,  16'd5000,  '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_HIGH,    16'd1000,  '0, '0, '0, '0, '0, '0},
    '{ROW_PIX,       REG_DEPTH_MODE, '0, 16'd0,     16'd29999, 16'd30000, '0, '0, '0},
    // lower segment of zero width
    '{ROW_CFG, REG_IN_LOW,     16'd100,   '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_MIDDLE,  16'd100,   '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_HIGH,    16'd900,   '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_OUT_LOW,    16'd50,    '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_OUT_HIGH,   16'd1050,  '0, '0, '0, '0, '0, '0},
    '{ROW_PIX_KNOWN, REG_DEPTH_MODE, '0, 16'd0,     16'd100,   16'd900,
      16'd550,   16'd550,   16'd1050},
    // upper segment of zero width gives the midpoint output
    '{ROW_CFG, REG_IN_MIDDLE,  16'd900,   '0, '0, '0, '0, '0, '0},
    '{ROW_PIX_KNOWN, REG_DEPTH_MODE, '0, 16'd900,   16'd65535, 16'd500,
      16'd550,   16'd550,   16'd300},
    // midpoint beyond the white point, upper segment reversed
    '{ROW_CFG, REG_IN_MIDDLE,  16'd2000,  '0, '0, '0, '0, '0, '0},
    '{ROW_PIX,       REG_DEPTH_MODE, '0, 16'd100,   16'd500,   16'd900,   '0, '0, '0},
    // falling output, negative half span
    '{ROW_CFG, REG_IN_LOW,     16'd0,     '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_MIDDLE,  16'd16384, '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_HIGH,    16'd32768, '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_OUT_LOW,    16'd30000, '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_OUT_HIGH,   16'd10,    '0, '0, '0, '0, '0, '0},
    '{ROW_PIX_KNOWN, REG_DEPTH_MODE, '0, 16'd0,     16'd32768, 16'd65535,
      16'd30000, 16'd10,    16'd10},
    '{ROW_PIX,       REG_DEPTH_MODE, '0, 16'd16384, 16'd8191,  16'd24577, '0, '0, '0},
    // 8-bit mode, output above the channel maximum saturates
    '{ROW_CFG, REG_DEPTH_MODE, 16'd0,     '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_MIDDLE,  16'd128,   '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_HIGH,    16'd255,   '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_OUT_LOW,    16'd0,     '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_OUT_HIGH,   16'd32768, '0, '0, '0, '0, '0, '0},
    '{ROW_PIX_KNOWN, REG_DEPTH_MODE, '0, 16'd255,   16'd0,     16'd300,
      16'd255,   16'd0,     16'd255},
    '{ROW_PIX,       REG_DEPTH_MODE, '0, 16'd100,   16'd128,   16'd1,     '0, '0, '0},
    // crossed points with falling output, result below zero clips to zero
    '{ROW_CFG, REG_IN_LOW,     16'd200,   '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_MIDDLE,  16'd150,   '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_IN_HIGH,    16'd100,   '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_OUT_LOW,    16'd255,   '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_OUT_HIGH,   16'd0,     '0, '0, '0, '0, '0, '0},
    '{ROW_PIX_KNOWN, REG_DEPTH_MODE, '0, 16'd150,   16'd0,     16'd65535,
      16'd254,   16'd254,   16'd0},
    // writes to unused indexes leave the setting alone
    '{ROW_CFG, REG_SPARE_A,    16'hffff,  '0, '0, '0, '0, '0, '0},
    '{ROW_CFG, REG_SPARE_B,    16'h1234,  '0, '0, '0, '0, '0, '0},
    '{ROW_PIX_KNOWN, REG_DEPTH_MODE, '0, 16'd150,   16'd0,     16'd65535,
      16'd254,   16'd254,   16'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [3*DATA_W-1:0]   in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [3*DATA_W-1:0]   out_tdata;
  logic                  cfg_we;
  logic [CFG_AW-1:0]     cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;

  levels_t levels;               // setting the expected pixels are worked out with
  pixel_t  pending_pixels[$];    // corrected pixels still owed by the block
  int      err_count    = 0;
  int      pixels_seen  = 0;
  int      idle_pct     = 30;    // chance of a gap before an item, 0 gives a solid stream

  levels_adjust u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- level mapper

  // floor of a / b, b positive
  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // nearest integer to num / den, halves rounded upwards
  function automatic longint nearest(longint num, longint den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    return floor_quot(2 * num + den, 2 * den);
  endfunction

  function automatic logic [DATA_W-1:0] level_map(logic [DATA_W-1:0] sample);
    longint ch_top, lo, md, hi, span, half, n, r, width;
    ch_top = levels.depth ? CHANNEL_MAX : MAX_8BIT;
    lo     = levels.in_low;
    md     = levels.in_mid;
    hi     = levels.in_high;
    span   = longint'(levels.out_high) - longint'(levels.out_low);
    half   = floor_quot(span, 2);
    n      = sample;
    // depth limit first, then the input window
    if (n > ch_top) n = ch_top;
    if (n < lo) n = lo;
    else if (n > hi) n = hi;
    if (n < md) begin
      width = md - lo;
      r = (width == 0) ? 0 : nearest((n - lo) * half, width);
    end else begin
      width = hi - md;
      r = (width == 0) ? half : half + nearest((n - md) * (span - half), width);
    end
    r += longint'(levels.out_low);
    if (r < 0) r = 0;
    else if (r > ch_top) r = ch_top;
    return r[DATA_W-1:0];
  endfunction

  function automatic pixel_t correct_pixel(pixel_t p);
    pixel_t c;
    c.red   = level_map(p.red);
    c.green = level_map(p.green);
    c.blue  = level_map(p.blue);
    return c;
  endfunction

  // ---------------------------------------------------------------- random values

  function automatic int gap_len();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // channel sample, weighted towards the edges of the current setting
  function automatic logic [DATA_W-1:0] pick_sample();
    logic [DATA_W-1:0] ch_top;
    logic [DATA_W-1:0] nudge;
    ch_top = levels.depth ? DATA_W'(CHANNEL_MAX) : DATA_W'(MAX_8BIT);
    nudge  = DATA_W'($urandom_range(2)) - 1'b1;
    case ($urandom_range(11))
      0:       return '0;
      1:       return ch_top;
      2:       return ch_top + 1'b1;
      3:       return '1;
      4:       return DATA_W'($urandom);
      5:       return levels.in_low + nudge;
      6:       return levels.in_mid + nudge;
      7:       return levels.in_high + nudge;
      default: return DATA_W'($urandom_range(0, ch_top));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_extreme(logic [DATA_W-1:0] ch_top);
    case ($urandom_range(4))
      0:       return '0;
      1:       return 16'd255;
      2:       return 16'd32768;
      3:       return '1;
      default: return ch_top;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic check_pixel(pixel_t got);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch("unexpected item, red", got.red, -1);
      return;
    end
    want = pending_pixels.pop_front();
    if (got.red   !== want.red)   report_mismatch("red",   got.red,   want.red);
    if (got.green !== want.green) report_mismatch("green", got.green, want.green);
    if (got.blue  !== want.blue)  report_mismatch("blue",  got.blue,  want.blue);
  endtask

  // ---------------------------------------------------------------- driving

  // one register write, the local copy follows at the same edge
  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    case (addr)
      REG_DEPTH_MODE: levels.depth    = val[0];
      REG_IN_LOW:     levels.in_low   = val;
      REG_IN_MIDDLE:  levels.in_mid   = val;
      REG_IN_HIGH:    levels.in_high  = val;
      REG_OUT_LOW:    levels.out_low  = val;
      REG_OUT_HIGH:   levels.out_high = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold the input, let every owed pixel come out, then idle for longer than the pipeline is deep
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (N_STAGES + 4) @(posedge clk);
  endtask

  // offer one pixel until taken; known rows carry their own expected pixel
  task automatic send_pixel(pixel_t px, bit known, pixel_t want);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    pending_pixels.push_back(known ? want : correct_pixel(px));
  endtask

  // random setting for one phase: tidy ordered points, extremes or raw bits
  task automatic random_setting(int phase);
    logic [DATA_W-1:0] ch_top, a, b, c, t;
    logic [DATA_W-1:0] vals[6];
    ch_top = phase[0] ? DATA_W'(CHANNEL_MAX) : DATA_W'(MAX_8BIT);
    case (phase % 3)
      0: begin
        a = DATA_W'($urandom_range(0, ch_top));
        b = DATA_W'($urandom_range(0, ch_top));
        c = DATA_W'($urandom_range(0, ch_top));
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
        vals[1] = a;
        vals[2] = b;
        vals[3] = c;
        vals[4] = DATA_W'($urandom_range(0, ch_top));
        vals[5] = DATA_W'($urandom_range(0, ch_top));
      end
      1: begin
        for (int i = 1; i < 6; i++) vals[i] = pick_extreme(ch_top);
      end
      default: begin
        for (int i = 1; i < 6; i++) vals[i] = DATA_W'($urandom);
      end
    endcase
    // upper bits of the depth write are junk and must be dropped
    cfg_write(REG_DEPTH_MODE, {(CFG_W-1)'($urandom), phase[0]});
    cfg_write(REG_IN_LOW,    vals[1]);
    cfg_write(REG_IN_MIDDLE, vals[2]);
    cfg_write(REG_IN_HIGH,   vals[3]);
    cfg_write(REG_OUT_LOW,   vals[4]);
    cfg_write(REG_OUT_HIGH,  vals[5]);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_tvalid && out_tready) begin
        check_pixel(out_tdata);
        pixels_seen++;
        // two long hold-offs so the pipeline fills and pushes back on the input
        if (pixels_seen == 400 || pixels_seen == 1300) stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = gap_len();
      end
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    stim_row_t row;
    pixel_t    px, want;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    levels    = '{1'b0, RST_IN_LOW, RST_IN_MIDDLE, RST_IN_HIGH, RST_OUT_LOW, RST_OUT_HIGH};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < N_ROWS; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        cfg_write(row.addr, row.val);
      end else begin
        px   = '{blue: row.b, green: row.g, red: row.r};
        want = '{blue: row.eb, green: row.eg, red: row.er};
        send_pixel(px, row.kind == ROW_PIX_KNOWN, want);
      end
    end

    // random phases, each with its own setting; every third one streams with no gaps
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      idle_pct = (p % 3 == 1) ? 0 : 30;
      random_setting(p);
      for (int k = 0; k < PHASE_PIX; k++) begin
        px.red   = pick_sample();
        px.green = pick_sample();
        px.blue  = pick_sample();
        send_pixel(px, 1'b0, '0);
      end
    end

    // drain, and watch a little longer for strays
    wait_idle();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
